/* rtl/fcdo_pkg.sv */
// Shared types, constants and the digit font for the frame counter overlay.
// No dependencies; the other files that use it refer to it by scoped names.

package fcdo_pkg;

   localparam int unsigned ORIGIN_X    = 10;
   localparam int unsigned ORIGIN_Y    = 10;
   localparam int unsigned GLYPH_W     = 4;
   localparam int unsigned GLYPH_H     = 5;
   localparam int unsigned GLYPH_PITCH = 5;
   localparam int unsigned MAX_DIM     = 4096;
   localparam int unsigned DIM_BITS    = 13;
   localparam int unsigned POS_BITS    = 12;
   localparam int unsigned CSR_ADDR_W  = 3;
   localparam int unsigned CSR_DATA_W  = 32;

   localparam logic [3:0]          BCD_MAX          = 4'd9;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET_VAL  = 13'd640;
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET_VAL = 13'd480;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [DIM_BITS-1:0] frame_width;
      logic [DIM_BITS-1:0] frame_height;
   } cfg_type;

   // Where the current raster position falls relative to the digit field.
   typedef struct packed {
      logic       row_hit;    // row inside the glyph band
      logic [2:0] cell_y;     // glyph row, valid with row_hit
      logic       col_hit;    // column on a glyph cell (not a gap)
      logic [1:0] cell_x;     // glyph column, valid with col_hit
      logic [3:0] digit;      // BCD digit shown at this column
      logic       frame_end;  // current position is the last of the frame
   } pos_type;

   // 4x5 font, bit 3 of a row is the leftmost column. Non-decimal codes are blank.
   function automatic logic glyph_bit(input logic [3:0] digit, input logic [2:0] cy,
                                      input logic [1:0] cx);
      logic [19:0] rows;
      logic [3:0]  row;
      case (digit)
         4'd0: rows = 20'h69996;
         4'd1: rows = 20'h26222;
         4'd2: rows = 20'h6924F;
         4'd3: rows = 20'h69296;
         4'd4: rows = 20'h89F11;
         4'd5: rows = 20'hF861E;
         4'd6: rows = 20'h78E96;
         4'd7: rows = 20'hF1248;
         4'd8: rows = 20'h69696;
         4'd9: rows = 20'h6971E;
         default: rows = 20'h00000;
      endcase
      case (cy)
         3'd0: row = rows[19:16];
         3'd1: row = rows[15:12];
         3'd2: row = rows[11:8];
         3'd3: row = rows[7:4];
         3'd4: row = rows[3:0];
         default: row = 4'h0;
      endcase
      return row[~cx];
   endfunction

endpackage

/* rtl/fcdo_req_if.sv */
// Input pixel channel: valid/ready handshake carrying one background pixel.
// Depends on nothing.

interface fcdo_req_if #(
   parameter int unsigned PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] bg_pixel;

   modport source (output valid, output bg_pixel, input ready);
   modport sink   (input valid, input bg_pixel, output ready);
endinterface

/* rtl/fcdo_rsp_if.sv */
// Result pixel channel: valid/ready handshake carrying the overlaid pixel.
// Depends on nothing.

interface fcdo_rsp_if #(
   parameter int unsigned PIXEL_BITS = 8
);
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] out_pixel;
   logic                  frame_end;

   modport source (output valid, output out_pixel, output frame_end, input ready);
   modport sink   (input valid, input out_pixel, input frame_end, output ready);
endinterface

/* rtl/fcdo_csr.sv */
// APB-style register file holding the frame width and height.
// Depends on fcdo_pkg.

module fcdo_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fcdo_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fcdo_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fcdo_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output fcdo_pkg::cfg_type                   cfg
);

   logic [fcdo_pkg::DIM_BITS-1:0] width_ff, width_in;
   logic [fcdo_pkg::DIM_BITS-1:0] height_ff, height_in;
   fcdo_pkg::reg_index_type       reg_sel;
   logic                          wr_en;

   assign reg_sel    = fcdo_pkg::reg_index_type'(csr_paddr[2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr_en) begin
         case (reg_sel)
            fcdo_pkg::REG_FRAME_WIDTH:  width_in  = csr_pwdata[fcdo_pkg::DIM_BITS-1:0];
            fcdo_pkg::REG_FRAME_HEIGHT: height_in = csr_pwdata[fcdo_pkg::DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         fcdo_pkg::REG_FRAME_WIDTH:
            csr_prdata = {{(fcdo_pkg::CSR_DATA_W-fcdo_pkg::DIM_BITS){1'b0}}, width_ff};
         fcdo_pkg::REG_FRAME_HEIGHT:
            csr_prdata = {{(fcdo_pkg::CSR_DATA_W-fcdo_pkg::DIM_BITS){1'b0}}, height_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= fcdo_pkg::WIDTH_RESET_VAL;
         height_ff <= fcdo_pkg::HEIGHT_RESET_VAL;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign cfg.frame_width  = width_ff;
   assign cfg.frame_height = height_ff;

endmodule

/* rtl/fcdo_raster.sv */
// Raster position tracking, digit-slot counters and the BCD frame counter.
// Depends on fcdo_pkg.

module fcdo_raster #(
   parameter int unsigned DIGIT_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  fcdo_pkg::cfg_type cfg,
   output fcdo_pkg::pos_type pos
);

   localparam int unsigned SLOT_BITS = $clog2(DIGIT_COUNT + 1);
   localparam int unsigned BCD_BITS  = 4 * DIGIT_COUNT;

   logic [fcdo_pkg::POS_BITS-1:0] column_ff, column_in;
   logic [fcdo_pkg::POS_BITS-1:0] row_ff, row_in;
   logic [2:0]                    cell_x_ff, cell_x_in;
   logic [SLOT_BITS-1:0]          slot_ff, slot_in;
   logic [BCD_BITS-1:0]           bcd_ff, bcd_in, bcd_inc;
   logic [DIGIT_COUNT:0]          carry;
   logic [fcdo_pkg::POS_BITS-1:0] width_lim, height_lim;
   logic                          line_end, frame_last, past_origin;
   logic [3:0]                    digit_sel;

   // Last valid index for a dimension: zero acts as one, oversize is clipped.
   function automatic logic [fcdo_pkg::POS_BITS-1:0] dim_limit(
         input logic [fcdo_pkg::DIM_BITS-1:0] v);
      logic [fcdo_pkg::DIM_BITS-1:0] lim;
      if (v == '0)
         lim = '0;
      else if (v > fcdo_pkg::DIM_BITS'(fcdo_pkg::MAX_DIM))
         lim = fcdo_pkg::DIM_BITS'(fcdo_pkg::MAX_DIM - 1);
      else
         lim = v - 1'b1;
      return lim[fcdo_pkg::POS_BITS-1:0];
   endfunction

   assign width_lim   = dim_limit(cfg.frame_width);
   assign height_lim  = dim_limit(cfg.frame_height);
   assign line_end    = column_ff >= width_lim;
   assign frame_last  = row_ff >= height_lim;
   assign past_origin = column_ff >= fcdo_pkg::POS_BITS'(fcdo_pkg::ORIGIN_X);

   always_comb begin
      digit_sel = '0;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         if (slot_ff == SLOT_BITS'(k))
            digit_sel = bcd_ff[4*(DIGIT_COUNT-1-k) +: 4];
      end
   end

   always_comb begin
      pos.row_hit   = (row_ff >= fcdo_pkg::POS_BITS'(fcdo_pkg::ORIGIN_Y)) &&
                      (row_ff < fcdo_pkg::POS_BITS'(fcdo_pkg::ORIGIN_Y + fcdo_pkg::GLYPH_H));
      pos.cell_y    = 3'(row_ff - fcdo_pkg::POS_BITS'(fcdo_pkg::ORIGIN_Y));
      pos.col_hit   = past_origin && (slot_ff < SLOT_BITS'(DIGIT_COUNT)) &&
                      (cell_x_ff < 3'(fcdo_pkg::GLYPH_W));
      pos.cell_x    = cell_x_ff[1:0];
      pos.digit     = digit_sel;
      pos.frame_end = line_end && frame_last;
   end

   // Ripple increment: a digit steps when every lower digit is at nine.
   always_comb begin
      carry[0] = 1'b1;
      for (int k = 0; k < DIGIT_COUNT; k++) begin
         carry[k+1] = carry[k] && (bcd_ff[4*k +: 4] >= fcdo_pkg::BCD_MAX);
         if (!carry[k])
            bcd_inc[4*k +: 4] = bcd_ff[4*k +: 4];
         else if (bcd_ff[4*k +: 4] >= fcdo_pkg::BCD_MAX)
            bcd_inc[4*k +: 4] = 4'd0;
         else
            bcd_inc[4*k +: 4] = bcd_ff[4*k +: 4] + 4'd1;
      end
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      cell_x_in = cell_x_ff;
      slot_in   = slot_ff;
      bcd_in    = bcd_ff;
      if (advance) begin
         if (line_end) begin
            column_in = '0;
            cell_x_in = '0;
            slot_in   = '0;
            if (frame_last) begin
               row_in = '0;
               bcd_in = bcd_inc;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            column_in = column_ff + 1'b1;
            // cell_x/slot track (column - origin) mod pitch and div pitch
            if (past_origin) begin
               if (cell_x_ff == 3'(fcdo_pkg::GLYPH_PITCH - 1)) begin
                  cell_x_in = '0;
                  if (slot_ff < SLOT_BITS'(DIGIT_COUNT))
                     slot_in = slot_ff + 1'b1;
               end else begin
                  cell_x_in = cell_x_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         cell_x_ff <= '0;
         slot_ff   <= '0;
         bcd_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         cell_x_ff <= cell_x_in;
         slot_ff   <= slot_in;
         bcd_ff    <= bcd_in;
      end
   end

endmodule

/* rtl/fcdo_render.sv */
// Glyph lookup and result register with the output handshake.
// Depends on fcdo_pkg.

module fcdo_render #(
   parameter int unsigned PIXEL_BITS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [PIXEL_BITS-1:0] bg_pixel,
   input  fcdo_pkg::pos_type     pos,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [PIXEL_BITS-1:0] out_pixel,
   output logic                  frame_end,
   output logic                  take_ready
);

   logic                  valid_ff, valid_in;
   logic [PIXEL_BITS-1:0] pixel_ff, pixel_in;
   logic                  end_ff, end_in;

   // A new pixel may enter when no result is held or the held result leaves in the same cycle.
   assign take_ready = !valid_ff || rsp_ready;

   always_comb begin
      if (pos.row_hit && pos.col_hit)
         pixel_in = fcdo_pkg::glyph_bit(pos.digit, pos.cell_y, pos.cell_x) ? '1 : '0;
      else
         pixel_in = bg_pixel;
      end_in = pos.frame_end;
   end

   always_comb begin
      valid_in = valid_ff;
      if (accept)
         valid_in = 1'b1;
      else if (rsp_ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pixel_ff <= pixel_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign out_pixel = pixel_ff;
   assign frame_end = end_ff;

endmodule

/* rtl/frame_counter_digit_overlay.sv */
// Top level of the frame number overlay: registers, raster tracker, renderer.
// Depends on fcdo_pkg, fcdo_req_if, fcdo_rsp_if, fcdo_csr, fcdo_raster, fcdo_render.
//
//   port group  direction  handshake              payload
//   req_ch      in         valid/ready            bg_pixel
//   rsp_ch      out        valid/ready            out_pixel, frame_end
//   csr_*       in/out     psel/penable, pready   paddr, pwdata, prdata
//
// One pixel per clock while rsp_ch takes results: a transfer on req_ch yields its result
// in the next cycle, set by the single result register after the glyph lookup.
// req_ch stays ready while rsp_ch is idle or transfers in the same cycle; a
// stalled result holds and blocks only the next input.
// Synchronous reset clears position, frame count and the result valid;
// registers return to 640 x 480. Size writes are expected while idle.

module frame_counter_digit_overlay #(
   parameter int unsigned DIGIT_COUNT = 8,
   parameter int unsigned PIXEL_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   fcdo_req_if.sink                        req_ch,
   fcdo_rsp_if.source                      rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fcdo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fcdo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fcdo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   fcdo_pkg::cfg_type cfg;
   fcdo_pkg::pos_type pos;
   logic              take_ready;
   logic              accept;

   assign req_ch.ready = take_ready;
   assign accept       = req_ch.valid && take_ready;

   fcdo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fcdo_raster #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_raster (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .cfg     (cfg),
      .pos     (pos)
   );

   fcdo_render #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_render (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .bg_pixel   (req_ch.bg_pixel),
      .pos        (pos),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .out_pixel  (rsp_ch.out_pixel),
      .frame_end  (rsp_ch.frame_end),
      .take_ready (take_ready)
   );

`ifndef SYNTHESIS
   // Every accepted pixel shows up as a result in the next cycle.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_ch.valid)
      else $error("accepted pixel produced no result");

   // A frame restarts at the origin, which lies outside the digit field.
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && pos.frame_end) |=> !pos.row_hit && !pos.col_hit)
      else $error("frame did not restart at the origin");

   // The frame counter never holds a non-decimal digit.
   a_bcd_digit: assert property (@(posedge clock) disable iff (reset)
      pos.digit <= fcdo_pkg::BCD_MAX)
      else $error("frame counter digit out of range");
`endif

endmodule
